// File: design/cefd_pkg.sv
`default_nettype none
package cefd_pkg;

	localparam int MAX_FRAMES  = 16;
	localparam int MAX_SLOTS   = 8;
	localparam int MAX_DEVICES = 16;

	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int SLOT_DEPTH = MAX_FRAMES * MAX_SLOTS;
	localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int SCW = $clog2(MAX_SLOTS + 1);

	localparam int CFG_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int NFW = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;
	localparam int DCW = ($clog2(MAX_DEVICES + 1) > 8) ? $clog2(MAX_DEVICES + 1) : 8;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_WFRAME  = 3'd1;
	localparam logic [2:0] OP_WSLOT   = 3'd2;
	localparam logic [2:0] OP_WWCET   = 3'd3;
	localparam logic [2:0] OP_RUNNING = 3'd4;
	localparam logic [2:0] OP_START   = 3'd5;

	localparam logic [1:0] KIND_ACK      = 2'd0;
	localparam logic [1:0] KIND_DISPATCH = 2'd1;
	localparam logic [1:0] KIND_DROP     = 2'd2;
	localparam logic [1:0] KIND_END      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICES = 2'd2;

	localparam logic [1:0] POL_DROP = 2'd0;

	typedef struct packed {
		logic [2:0]  operation;
		logic [63:0] time_us;
		logic [3:0]  frame_index;
		logic [2:0]  slot_index;
		logic [7:0]  device_id;
		logic [31:0] value;
		logic [3:0]  slot_count;
		logic        running;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  device_out;
		logic [3:0]  frame_out;
		logic [31:0] used_us;
		logic        cut_short;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SUM,
		ST_CMP,
		ST_BEGIN,
		ST_SLOT,
		ST_ACK,
		ST_END
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply_write;
		logic calc_end;
		logic begin_frame;
		logic slot_step;
		logic emit_ack;
		logic emit_end;
	} cmd_t;

	typedef struct packed {
		logic in_is_tick;
		logic no_frames;
		logic due;
		logic frame_active;
		logic slot_done;
		logic slot_emit;
		logic slot_stop;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// File: design/cefd_ctrl.sv
`default_nettype none
module cefd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire cefd_pkg::status_t st,
	output cefd_pkg::cmd_t         cmd
);
	import cefd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = st.in_is_tick ? ST_SUM : ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_ACK;
			ST_SUM:   state_d = ST_CMP;
			ST_CMP: begin
				if (st.no_frames || !st.due) begin
					state_d = ST_ACK;
				end else if (st.frame_active) begin
					state_d = ST_BEGIN;
				end else begin
					state_d = ST_END;
				end
			end
			ST_BEGIN: state_d = ST_SLOT;
			ST_SLOT: begin
				if (st.slot_done) begin
					state_d = ST_END;
				end else if (!(st.slot_emit && !st.out_free) && st.slot_stop) begin
					state_d = ST_END;
				end
			end
			ST_ACK: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_END: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  cmd.capture = in_valid;
			ST_WRITE: cmd.apply_write = 1'b1;
			ST_SUM:   cmd.calc_end = 1'b1;
			ST_BEGIN: cmd.begin_frame = 1'b1;
			ST_SLOT:  cmd.slot_step = !st.slot_done && !(st.slot_emit && !st.out_free);
			ST_ACK:   cmd.emit_ack = st.out_free;
			ST_END:   cmd.emit_end = st.out_free;
			default: begin
			end
		endcase
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ack || cmd.emit_end || (cmd.slot_step && st.slot_emit)) |-> st.out_free)
		else $error("result issued while output register busy");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

endmodule
`default_nettype wire

// File: design/cefd_dp.sv
`default_nettype none
module cefd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cefd_pkg::in_item_t            in_item,
	output cefd_pkg::out_item_t                out_item,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	input  wire logic                          cfg_we,
	input  wire logic [cefd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cefd_pkg::CFG_W-1:0]    cfg_data,
	input  wire cefd_pkg::cmd_t                cmd,
	output cefd_pkg::status_t                  st
);
	import cefd_pkg::*;

	logic [1:0]       policy_q;
	logic [CFG_W-1:0] frames_q;
	logic [CFG_W-1:0] devices_q;

	in_item_t         in_q;
	logic [63:0]      end_q;
	logic [63:0]      start_q;
	logic [FW-1:0]    cf_q;
	logic [31:0]      used_q;
	logic             cut_q;
	logic [SCW-1:0]   idx_q;
	logic [SCW-1:0]   cnt_q;

	logic [31:0]      duration_q [MAX_FRAMES];
	logic [SCW-1:0]   slots_q [MAX_FRAMES];
	logic [31:0]      wcet_q [MAX_DEVICES];
	logic [MAX_DEVICES-1:0] running_q;
	logic [7:0]       slot_mem [SLOT_DEPTH];
	logic [7:0]       slot_rd_q;

	out_item_t        out_q;
	logic             out_valid_q;

	logic [NFW-1:0]   nframes;
	logic [DCW-1:0]   ndev;
	logic [31:0]      dur_cur;
	logic [64:0]      end_sum;
	logic [DW-1:0]    dev_sel;
	logic             dev_take;
	logic [32:0]      would;
	logic             over;
	logic             out_free;
	logic             slot_rd_en;
	logic [SCW-1:0]   rd_idx;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [SCW-1:0]   sc_sat;
	logic [31:0]      used_next;

	assign nframes = (NFW'(frames_q) > NFW'(MAX_FRAMES)) ?
		NFW'(MAX_FRAMES) : NFW'(frames_q);
	assign ndev = (DCW'(devices_q) > DCW'(MAX_DEVICES)) ?
		DCW'(MAX_DEVICES) : DCW'(devices_q);
	assign dur_cur = duration_q[cf_q];
	assign end_sum = {1'b0, start_q} + {33'd0, dur_cur};

	assign dev_sel  = DW'(slot_rd_q);
	assign dev_take = (DCW'(slot_rd_q) < ndev) && running_q[dev_sel];
	assign would    = {1'b0, used_q} + {1'b0, wcet_q[dev_sel]};
	assign over     = would > {1'b0, dur_cur};
	assign used_next = over ? ((policy_q == POL_DROP) ? used_q : dur_cur) : would[31:0];

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign st.in_is_tick   = (in_item.operation == OP_TICK);
	assign st.no_frames    = (nframes == '0);
	assign st.due          = (in_q.time_us >= end_q);
	assign st.frame_active = ({{(NFW-FW){1'b0}}, cf_q} < nframes);
	assign st.slot_done    = (idx_q >= cnt_q);
	assign st.slot_emit    = dev_take;
	assign st.slot_stop    = dev_take &&
		((over && policy_q != POL_DROP) || (!over && would >= {1'b0, dur_cur}));
	assign st.out_free     = out_free;

	assign slot_rd_en = cmd.begin_frame || cmd.slot_step;
	assign rd_idx     = cmd.begin_frame ? '0 : idx_q + SCW'(1);
	assign rd_addr    = AW'(cf_q) * AW'(MAX_SLOTS) + AW'(rd_idx);
	assign wr_addr    = AW'(in_q.frame_index) * AW'(MAX_SLOTS) + AW'(in_q.slot_index);
	assign sc_sat     = (in_q.slot_count > 4'(MAX_SLOTS)) ?
		SCW'(MAX_SLOTS) : SCW'(in_q.slot_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_DROP;
			frames_q  <= CFG_W'(1);
			devices_q <= CFG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLICY:  policy_q  <= cfg_data[1:0];
				CFG_FRAMES:  frames_q  <= cfg_data;
				CFG_DEVICES: devices_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_item;
		end
		if (cmd.calc_end) begin
			end_q <= end_sum[64] ? '1 : end_sum[63:0];
		end
		if (cmd.begin_frame) begin
			cnt_q <= slots_q[cf_q];
		end
		if (cmd.apply_write && in_q.operation == OP_WFRAME &&
				{1'b0, in_q.frame_index} < MAX_FRAMES) begin
			duration_q[FW'(in_q.frame_index)] <= in_q.value;
		end
		if (cmd.apply_write && in_q.operation == OP_WWCET &&
				{1'b0, in_q.device_id} < MAX_DEVICES) begin
			wcet_q[DW'(in_q.device_id)] <= in_q.value;
		end
		if (cmd.apply_write && in_q.operation == OP_WSLOT &&
				{1'b0, in_q.frame_index} < MAX_FRAMES &&
				{1'b0, in_q.slot_index} < MAX_SLOTS) begin
			slot_mem[wr_addr] <= in_q.device_id;
		end
		if (slot_rd_en) begin
			slot_rd_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q   <= '{default: '0};
			running_q <= '1;
			cf_q      <= '0;
			start_q   <= '0;
			used_q    <= '0;
			cut_q     <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.capture) begin
				cut_q <= 1'b0;
			end
			if (cmd.apply_write) begin
				case (in_q.operation)
					OP_WFRAME: begin
						if ({1'b0, in_q.frame_index} < MAX_FRAMES) begin
							slots_q[FW'(in_q.frame_index)] <= sc_sat;
						end
					end
					OP_RUNNING: begin
						if ({1'b0, in_q.device_id} < MAX_DEVICES) begin
							running_q[DW'(in_q.device_id)] <= in_q.running;
						end
					end
					OP_START: begin
						start_q   <= in_q.time_us;
						cf_q      <= '0;
						used_q    <= '0;
						running_q <= '1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.begin_frame) begin
				used_q <= '0;
				idx_q  <= '0;
			end
			if (cmd.slot_step) begin
				idx_q <= idx_q + SCW'(1);
				if (dev_take) begin
					used_q <= used_next;
					if (over && policy_q != POL_DROP) begin
						cut_q <= 1'b1;
					end
				end
			end
			if (cmd.emit_end) begin
				start_q <= end_q;
				if ({{(NFW-FW){1'b0}}, cf_q} + NFW'(1) >= nframes) begin
					cf_q <= '0;
				end else begin
					cf_q <= cf_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ack || cmd.emit_end || (cmd.slot_step && dev_take)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ack) begin
			out_q.kind       <= KIND_ACK;
			out_q.device_out <= '0;
			out_q.frame_out  <= 4'(cf_q);
			out_q.used_us    <= used_q;
			out_q.cut_short  <= 1'b0;
			out_q.last       <= 1'b1;
		end else if (cmd.emit_end) begin
			out_q.kind       <= KIND_END;
			out_q.device_out <= '0;
			out_q.frame_out  <= 4'(cf_q);
			out_q.used_us    <= used_q;
			out_q.cut_short  <= cut_q;
			out_q.last       <= 1'b1;
		end else if (cmd.slot_step && dev_take) begin
			out_q.kind       <= over ? KIND_DROP : KIND_DISPATCH;
			out_q.device_out <= slot_rd_q;
			out_q.frame_out  <= 4'(cf_q);
			out_q.used_us    <= used_next;
			out_q.cut_short  <= 1'b0;
			out_q.last       <= 1'b0;
		end
	end

	a_used_in_budget: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_step |=> (used_q <= dur_cur))
		else $error("frame budget exceeded");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last == (out_q.kind == KIND_ACK || out_q.kind == KIND_END)))
		else $error("last flag does not match result kind");

	a_slot_read_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_step |-> (idx_q < cnt_q))
		else $error("slot walk past frame slot count");

endmodule
`default_nettype wire

// File: design/cyclic_executive_frame_dispatcher.sv
// Time-triggered minor-frame dispatcher.
// Input channel (in_valid / in_stall / in_item): one operation per item, either a
// table load (frame, slot, WCET, running flag), a start, or a time tick.
// Output channel (out_valid / out_stall / out_item): every item gives one or more
// results; the final result of an item has last set.
// Configuration port (cfg_we / cfg_index / cfg_data): overrun policy, frames in
// use, devices in use; write only while no item is in progress.
// A load or start gives its result after the table write. A tick first computes the
// frame end and compares it with its time; if it is not due, or no frames are in use,
// it gives only an acknowledge. A due tick gives a result for each slot that names a
// running device in range (up to 8 slots, until the budget stops the walk), then the
// frame-end result. One item is taken at a time. The slot walk reads one slot table
// entry per cycle from the slot memory while the output register is free. The next
// item is accepted while the last result still waits in the output register. A stalled
// receiver holds the output register; the slot walk pauses on each slot that needs a result until the register frees.
// Reset clears the schedule position, frame start and used budget, sets all devices
// running and all frame slot counts to zero; durations, slots and WCETs need loading.
`default_nettype none
module cyclic_executive_frame_dispatcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire cefd_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output cefd_pkg::out_item_t                 out_item,
	input  wire logic                           cfg_we,
	input  wire logic [cefd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cefd_pkg::CFG_W-1:0]     cfg_data
);
	import cefd_pkg::*;

	cmd_t    cmd;
	status_t st;

	cefd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	cefd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire

// File: dv/tb_cyclic_executive_frame_dispatcher.sv
`timescale 1ns / 1ps
module tb_cyclic_executive_frame_dispatcher;
	import cefd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 230;
	localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] POL_SKIP = 2'd1;
	localparam logic [1:0] POL_FAULT = 2'd2;
	localparam logic [1:0] POL_RESET = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [31:0] sched_dur [MAX_FRAMES];
	logic [3:0] sched_slots [MAX_FRAMES];
	logic [7:0] slot_dev [MAX_FRAMES*MAX_SLOTS];
	logic [31:0] dev_wcet [MAX_DEVICES];
	logic dev_run [MAX_DEVICES];
	bit dur_set [MAX_FRAMES];
	bit slot_set [MAX_FRAMES*MAX_SLOTS];
	bit wcet_set [MAX_DEVICES];
	logic [3:0] cur_frame;
	logic [63:0] start_us;
	logic [31:0] used_budget;
	logic [1:0] pol;
	logic [4:0] nfr;
	logic [4:0] ndv;

	out_item_t awaited [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int work_items = 0;
	bit steady = 0;

	cyclic_executive_frame_dispatcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[cyclic_executive_frame_dispatcher] ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? TIME_MAX : s[63:0];
	endfunction

	function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
		input logic [31:0] u, input logic c, input logic fin);
		out_item_t r;
		r.kind = k;
		r.device_out = d;
		r.frame_out = cur_frame;
		r.used_us = u;
		r.cut_short = c;
		r.last = fin;
		awaited.push_back(r);
	endfunction

	function automatic void predict_frame_walk(input logic [63:0] now);
		int nf;
		int nd;
		int cnt;
		logic [3:0] cf;
		logic [31:0] dur;
		logic [32:0] would;
		logic [7:0] dv;
		logic cut;
		nf = (nfr > MAX_FRAMES) ? MAX_FRAMES : int'(nfr);
		nd = (ndv > MAX_DEVICES) ? MAX_DEVICES : int'(ndv);
		cf = cur_frame;
		dur = sched_dur[cf];
		cut = 1'b0;
		if (nf == 0 || now < sat_add64(start_us, {32'd0, dur})) begin
			push_result(KIND_ACK, 8'd0, used_budget, 1'b0, 1'b1);
			return;
		end
		if (int'(cf) < nf) begin
			cnt = (sched_slots[cf] > MAX_SLOTS) ? MAX_SLOTS : int'(sched_slots[cf]);
			used_budget = '0;
			for (int i = 0; i < cnt; i++) begin
				dv = slot_dev[int'(cf) * MAX_SLOTS + i];
				if (dv >= nd || !dev_run[dv])
					continue;
				would = {1'b0, used_budget} + {1'b0, dev_wcet[dv]};
				if (would > {1'b0, dur}) begin
					if (pol == POL_DROP) begin
						push_result(KIND_DROP, dv, used_budget, 1'b0, 1'b0);
						continue;
					end
					used_budget = dur;
					push_result(KIND_DROP, dv, used_budget, 1'b0, 1'b0);
					cut = 1'b1;
					break;
				end
				used_budget = would[31:0];
				push_result(KIND_DISPATCH, dv, used_budget, 1'b0, 1'b0);
				if (used_budget >= dur)
					break;
			end
		end
		push_result(KIND_END, 8'd0, used_budget, cut, 1'b1);
		start_us = sat_add64(start_us, {32'd0, dur});
		if (int'(cf) + 1 >= nf)
			cur_frame = '0;
		else
			cur_frame = cf + 4'd1;
	endfunction

	function automatic void predict_results(input in_item_t it);
		int idx;
		idx = int'(it.frame_index) * MAX_SLOTS + int'(it.slot_index);
		case (it.operation)
			OP_TICK: begin
				work_items++;
				predict_frame_walk(it.time_us);
				return;
			end
			OP_WFRAME: begin
				work_items++;
				sched_dur[it.frame_index] = it.value;
				sched_slots[it.frame_index] = (it.slot_count > MAX_SLOTS) ? MAX_SLOTS : it.slot_count;
				dur_set[it.frame_index] = 1'b1;
			end
			OP_WSLOT: begin
				work_items++;
				slot_dev[idx] = it.device_id;
				slot_set[idx] = 1'b1;
			end
			OP_WWCET: begin
				if (it.device_id < MAX_DEVICES) begin
					work_items++;
					dev_wcet[it.device_id] = it.value;
					wcet_set[it.device_id] = 1'b1;
				end
			end
			OP_RUNNING: begin
				if (it.device_id < MAX_DEVICES) begin
					work_items++;
					dev_run[it.device_id] = it.running;
				end
			end
			OP_START: begin
				work_items++;
				start_us = it.time_us;
				cur_frame = '0;
				used_budget = '0;
				for (int d = 0; d < MAX_DEVICES; d++)
					dev_run[d] = 1'b1;
			end
			default: ;
		endcase
		push_result(KIND_ACK, 8'd0, used_budget, 1'b0, 1'b1);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing pending", got));
			return;
		end
		want = awaited.pop_front();
		if (got.kind !== want.kind)
			report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
		if (got.device_out !== want.device_out)
			report_mismatch($sformatf("device_out %0d, want %0d", got.device_out,
				want.device_out));
		if (got.frame_out !== want.frame_out)
			report_mismatch($sformatf("frame_out %0d, want %0d", got.frame_out,
				want.frame_out));
		if (got.used_us !== want.used_us)
			report_mismatch($sformatf("used_us %0d, want %0d", got.used_us, want.used_us));
		if (got.cut_short !== want.cut_short)
			report_mismatch($sformatf("cut_short %b, want %b", got.cut_short, want.cut_short));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, want %b", got.last, want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_item);
	end

	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ((cycles % 16) < 10);
			endcase
		end
	end

	function automatic in_item_t random_item();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		predict_results(it);
	endtask

	task automatic send_write(input logic [2:0] op, input logic [3:0] frame,
		input logic [2:0] slot, input logic [7:0] dev, input logic [31:0] val,
		input logic [3:0] cnt, input logic run);
		in_item_t it;
		it = random_item();
		it.operation = op;
		it.frame_index = frame;
		it.slot_index = slot;
		it.device_id = dev;
		it.value = val;
		it.slot_count = cnt;
		it.running = run;
		send_item(it);
	endtask

	task automatic send_start(input logic [63:0] t);
		in_item_t it;
		it = random_item();
		it.operation = OP_START;
		it.time_us = t;
		send_item(it);
	endtask

	// fill any table entry the next tick could read before it was written
	task automatic load_missing_tables();
		int cf;
		int idx;
		cf = cur_frame;
		if (!dur_set[cf])
			send_write(OP_WFRAME, cf, $urandom, $urandom, $urandom_range(20, 300),
				sched_slots[cf], $urandom);
		for (int i = 0; i < MAX_SLOTS; i++) begin
			idx = cf * MAX_SLOTS + i;
			if (i < sched_slots[cf] && !slot_set[idx])
				send_write(OP_WSLOT, cf, i, $urandom_range(0, MAX_DEVICES - 1), $urandom,
					$urandom, $urandom);
			if (i < sched_slots[cf] && slot_dev[idx] < MAX_DEVICES && !wcet_set[slot_dev[idx]])
				send_write(OP_WWCET, $urandom, $urandom, slot_dev[idx], $urandom_range(1, 80),
					$urandom, $urandom);
		end
	endtask

	task automatic send_tick(input bit due, input logic [63:0] slack);
		in_item_t it;
		logic [63:0] frame_end;
		load_missing_tables();
		frame_end = sat_add64(start_us, {32'd0, sched_dur[cur_frame]});
		it = random_item();
		it.operation = OP_TICK;
		if (due)
			it.time_us = sat_add64(frame_end, slack);
		else
			it.time_us = (frame_end > slack) ? frame_end - slack : 64'd0;
		send_item(it);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLICY: pol = data[1:0];
			CFG_FRAMES: nfr = data;
			CFG_DEVICES: ndv = data;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed_schedule();
		write_register(CFG_POLICY, POL_DROP);
		write_register(CFG_FRAMES, 5'd2);
		write_register(CFG_DEVICES, 5'd4);
		write_register(CFG_SPARE, 5'd31);
		send_write(OP_SPARE_A, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		send_write(OP_SPARE_B, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd0, 32'd30, 4'd0, 1'b0);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd1, 32'd50, 4'd0, 1'b0);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd2, 32'd40, 4'd0, 1'b0);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd3, 32'd20, 4'd0, 1'b0);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd200, 32'd7, 4'd0, 1'b0);
		send_write(OP_RUNNING, 4'd0, 3'd0, 8'd255, 32'd0, 4'd0, 1'b0);
		send_write(OP_WFRAME, 4'd0, 3'd0, 8'd0, 32'd100, 4'd5, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd0, 8'd0, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd1, 8'd2, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd2, 8'd9, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd3, 8'd1, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd4, 8'd3, 32'd0, 4'd0, 1'b0);
		send_write(OP_WFRAME, 4'd1, 3'd0, 8'd0, 32'd60, 4'd15, 1'b0);
		send_write(OP_WSLOT, 4'd1, 3'd0, 8'd1, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd1, 3'd1, 8'd0, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd1, 3'd2, 8'd3, 32'd0, 4'd0, 1'b0);
		send_start({32'd0, $urandom});
		send_write(OP_RUNNING, 4'd0, 3'd0, 8'd2, 32'd0, 4'd0, 1'b0);
		send_tick(1'b0, 64'd50);
		send_tick(1'b1, 64'd0);
		send_tick(1'b1, 64'd7);
	endtask

	task automatic test_overrun_and_frame_limits();
		wait_idle();
		write_register(CFG_POLICY, POL_SKIP);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd0, 32'd90, 4'd0, 1'b0);
		send_start({32'd0, $urandom});
		send_tick(1'b1, 64'd0);
		send_tick(1'b1, 64'd3);
		wait_idle();
		write_register(CFG_FRAMES, 5'd0);
		send_tick(1'b1, 64'd0);
		wait_idle();
		write_register(CFG_FRAMES, 5'd31);
		write_register(CFG_DEVICES, 5'd0);
		send_tick(1'b1, 64'd0);
		wait_idle();
		write_register(CFG_FRAMES, 5'd1);
		write_register(CFG_DEVICES, 5'd16);
		write_register(CFG_POLICY, POL_RESET);
		send_tick(1'b1, 64'd0);
		wait_idle();
		write_register(CFG_POLICY, POL_FAULT);
		send_tick(1'b1, 64'd1);
	endtask

	task automatic test_time_saturation();
		wait_idle();
		write_register(CFG_POLICY, POL_DROP);
		write_register(CFG_FRAMES, 5'd2);
		write_register(CFG_DEVICES, 5'd31);
		send_write(OP_WWCET, 4'd0, 3'd0, 8'd5, 32'hFFFF_FFFF, 4'd0, 1'b0);
		send_write(OP_WFRAME, 4'd0, 3'd0, 8'd0, 32'hFFFF_FFFF, 4'd2, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd0, 8'd5, 32'd0, 4'd0, 1'b0);
		send_write(OP_WSLOT, 4'd0, 3'd1, 8'd4, 32'd0, 4'd0, 1'b0);
		send_start(TIME_MAX - 64'd1000);
		send_tick(1'b0, 64'd1);
		send_tick(1'b1, 64'd0);
		send_tick(1'b1, TIME_MAX);
		send_tick(1'b1, TIME_MAX);
	endtask

	task automatic test_random_schedules();
		int goal;
		int nf;
		int f;
		int sc;
		in_item_t it;
		logic [31:0] dur;
		goal = work_items + RANDOM_ITEMS;
		while (work_items < goal) begin
			wait_idle();
			steady = ($urandom_range(0, 3) == 0);
			write_register(CFG_POLICY, $urandom_range(0, 3));
			case ($urandom_range(0, 7))
				0: write_register(CFG_FRAMES, 5'd0);
				1: write_register(CFG_FRAMES, 5'd16);
				2: write_register(CFG_FRAMES, $urandom_range(17, 31));
				default: write_register(CFG_FRAMES, $urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 7))
				0: write_register(CFG_DEVICES, 5'd0);
				1: write_register(CFG_DEVICES, 5'd16);
				2: write_register(CFG_DEVICES, $urandom_range(17, 31));
				default: write_register(CFG_DEVICES, $urandom_range(1, 10));
			endcase
			nf = (nfr > MAX_FRAMES) ? MAX_FRAMES : ((nfr == 0) ? 1 : int'(nfr));
			repeat ($urandom_range(1, 3)) begin
				f = $urandom_range(0, nf - 1);
				case ($urandom_range(0, 9))
					0: dur = 32'd0;
					1: dur = $urandom;
					default: dur = $urandom_range(20, 300);
				endcase
				sc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
				send_write(OP_WFRAME, f, $urandom, $urandom, dur, sc, $urandom);
				for (int i = 0; i < sc && i < MAX_SLOTS; i++)
					send_write(OP_WSLOT, f, i,
						($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, ndv + 1),
						$urandom, $urandom, $urandom);
			end
			repeat ($urandom_range(1, 4))
				send_write(OP_WWCET, $urandom, $urandom, $urandom_range(0, MAX_DEVICES - 1),
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120),
					$urandom, $urandom);
			if ($urandom_range(0, 7) == 0)
				send_start(TIME_MAX - $urandom_range(0, 2000));
			else
				send_start({$urandom, $urandom});
			repeat ($urandom_range(4, 14)) begin
				if ($urandom_range(0, 99) < 15) begin
					it = random_item();
					case ($urandom_range(0, 4))
						0: begin
							it.operation = OP_RUNNING;
							it.device_id = $urandom_range(0, MAX_DEVICES - 1);
						end
						1: it.operation = OP_RUNNING;
						2: it.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
						3: begin
							it.operation = OP_WWCET;
							it.value = $urandom_range(0, 150);
						end
						default: it.operation = OP_START;
					endcase
					send_item(it);
				end else if ($urandom_range(0, 99) < 85) begin
					send_tick(1'b1, ($urandom_range(0, 2) == 0) ? 64'd0 : $urandom_range(1, 5));
				end else begin
					send_tick(1'b0, $urandom_range(1, 40));
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			sched_dur[i] = '0;
			sched_slots[i] = '0;
			dur_set[i] = 1'b0;
		end
		for (int i = 0; i < MAX_FRAMES * MAX_SLOTS; i++) begin
			slot_dev[i] = '0;
			slot_set[i] = 1'b0;
		end
		for (int i = 0; i < MAX_DEVICES; i++) begin
			dev_wcet[i] = '0;
			dev_run[i] = 1'b1;
			wcet_set[i] = 1'b0;
		end
		cur_frame = '0;
		start_us = '0;
		used_budget = '0;
		pol = POL_DROP;
		nfr = 5'd1;
		ndv = 5'd16;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_schedule();
		test_overrun_and_frame_limits();
		test_time_saturation();
		test_random_schedules();
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[cyclic_executive_frame_dispatcher] OK");
		else
			$display("[cyclic_executive_frame_dispatcher] ERROR");
		$finish;
	end

endmodule

// File: files.f
design/cefd_pkg.sv
design/cefd_ctrl.sv
design/cefd_dp.sv
design/cyclic_executive_frame_dispatcher.sv
dv/tb_cyclic_executive_frame_dispatcher.sv
